// ===== hw/rtl/line_sensor_position_debounce_top_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef LINE_SENSOR_POSITION_DEBOUNCE_TOP_MACROS_SVH
`define LINE_SENSOR_POSITION_DEBOUNCE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define LSPD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lspd assertion failed");
`define LSPD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lspd forbidden condition seen");
`else
`define LSPD_ASSERT(label, clk, rst_n, prop)
`define LSPD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/lspd_pkg.sv =====
package lspd_pkg;

  localparam int SENSOR_COUNT = 12;
  localparam int ERR_W = 7;
  localparam int THR_W = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd20;
  localparam int ERR_MAX = 55;
  localparam int ERR_MIN = -55;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  typedef logic [SENSOR_COUNT-1:0] sens_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [THR_W-1:0] thr_t;

  typedef enum logic [1:0] {
    KIND_DARK,
    KIND_LINE,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    kind_t kind;
    err_t  err;
  } word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic err_t err_clamp(input int e);
    int c;
    c = e;
    if (c > ERR_MAX) c = ERR_MAX;
    if (c < ERR_MIN) c = ERR_MIN;
    return err_t'(c);
  endfunction

  function automatic err_t err_single(input int idx);
    return err_clamp(55 - 10 * idx);
  endfunction

  function automatic err_t err_pair(input int idx);
    return err_clamp(50 - 10 * idx);
  endfunction

endpackage

// ===== hw/rtl/lspd_front.sv =====
`include "line_sensor_position_debounce_top_macros.svh"

module lspd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lspd_pkg::sens_t     in_sensors,
  input  lspd_pkg::qstat_t    q_stat,
  output logic                push,
  output lspd_pkg::word_t     push_word
);
  import lspd_pkg::*;

  logic  front_valid_r, front_valid_nxt;
  word_t word_r;
  word_t word_c;
  logic  in_fire;

  // classify the sensor pattern
  always_comb begin
    word_c.kind = KIND_OTHER;
    word_c.err  = '0;
    if (in_sensors == '0) begin
      word_c.kind = KIND_DARK;
    end
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (in_sensors == (sens_t'(1) << i)) begin
        word_c.kind = KIND_LINE;
        word_c.err  = err_single(i);
      end
    end
    for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
      if (in_sensors == (sens_t'(3) << i)) begin
        word_c.kind = KIND_LINE;
        word_c.err  = err_pair(i);
      end
    end
  end

  assign push      = front_valid_r && !q_stat.full;
  assign in_stall  = front_valid_r && q_stat.full;
  assign in_fire   = in_valid && !in_stall;
  assign push_word = word_r;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (in_fire) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= word_c;
    end
  end

  `LSPD_ASSERT(a_stall_only_when_held, clk, rst_n, in_stall |-> front_valid_r)
  `LSPD_ASSERT(a_held_word_moves, clk, rst_n,
    (front_valid_r && !q_stat.full && !in_valid) |=> !front_valid_r)

endmodule

// ===== hw/rtl/lspd_queue.sv =====
`include "line_sensor_position_debounce_top_macros.svh"

module lspd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lspd_pkg::word_t   push_word,
  input  logic              pop,
  output lspd_pkg::word_t   pop_word,
  output lspd_pkg::qstat_t  q_stat
);
  import lspd_pkg::*;

  word_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_word     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  `LSPD_ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && q_stat.empty)
  `LSPD_ASSERT_NEVER(a_push_when_full, clk, rst_n, push && q_stat.full)

endmodule

// ===== hw/rtl/lspd_back.sv =====
`include "line_sensor_position_debounce_top_macros.svh"

module lspd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lspd_pkg::qstat_t  q_stat,
  input  lspd_pkg::word_t   pop_word,
  output logic              pop,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  lspd_pkg::thr_t    cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lspd_pkg::err_t    out_turn_error,
  output logic              out_line_seen,
  output logic              out_line_stable
);
  import lspd_pkg::*;

  thr_t thr_r;
  err_t held_error_r, held_error_nxt;
  logic line_flag_r, line_flag_nxt;
  logic prev_flag_r, prev_flag_nxt;
  thr_t run_count_r, run_count_nxt;
  logic stable_r, stable_nxt;
  logic out_valid_r, out_valid_nxt;
  err_t out_err_r;
  logic out_seen_r, out_stable_r;

  assign cfg_ready = 1'b1;
  assign pop       = !q_stat.empty && (!out_valid_r || !out_stall);

  // decode result and debounce
  always_comb begin
    held_error_nxt = held_error_r;
    line_flag_nxt  = line_flag_r;
    prev_flag_nxt  = prev_flag_r;
    run_count_nxt  = run_count_r;
    stable_nxt     = stable_r;
    case (pop_word.kind)
      KIND_DARK: line_flag_nxt = 1'b0;
      KIND_LINE: begin
        line_flag_nxt  = 1'b1;
        held_error_nxt = pop_word.err;
      end
      default: ;
    endcase
    if (line_flag_nxt == prev_flag_r) begin
      if (run_count_r < thr_r) begin
        run_count_nxt = run_count_r + 1'b1;
      end
      if (run_count_nxt >= thr_r) begin
        stable_nxt = line_flag_nxt;
      end
    end else begin
      run_count_nxt = thr_t'(1);
      prev_flag_nxt = line_flag_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= THR_RESET;
      held_error_r <= '0;
      line_flag_r  <= 1'b0;
      prev_flag_r  <= 1'b0;
      run_count_r  <= '0;
      stable_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (pop) begin
        held_error_r <= held_error_nxt;
        line_flag_r  <= line_flag_nxt;
        prev_flag_r  <= prev_flag_nxt;
        run_count_r  <= run_count_nxt;
        stable_r     <= stable_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_err_r    <= held_error_nxt;
      out_seen_r   <= line_flag_nxt;
      out_stable_r <= stable_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_turn_error  = out_err_r;
  assign out_line_seen   = out_seen_r;
  assign out_line_stable = out_stable_r;

  `LSPD_ASSERT_NEVER(a_no_pop_over_stalled, clk, rst_n, out_valid_r && out_stall && pop)
  `LSPD_ASSERT(a_pop_gives_word, clk, rst_n, pop |=> out_valid_r)

endmodule

// ===== hw/rtl/line_sensor_position_debounce_top.sv =====
// line sensor position decoder with debounced line flag
// input channel: in_valid / in_stall carry one 12-bit sensor word, bit i is
//   sensor i; a word is taken on a clock edge with in_valid high and
//   in_stall low
// output channel: out_valid / out_stall carry one result word per input word:
//   out_turn_error (signed, steps of 5), out_line_seen, out_line_stable
// config channel: cfg_valid / cfg_ready write the 8-bit debounce threshold;
//   cfg_ready is always high, write only while no word is in flight
// path: a result passes the front classify register, the two-entry queue and
//   the back state and output register before it is shown
// throughput: one word per cycle while out_stall stays low; the back stage
//   updates error and debounce state once per word
// out_stall holds the result; the output register, the queue and the front
//   register take up to four words before in_stall rises
// reset (rst_n low, synchronous): error, flags and run count clear, the
//   threshold returns to 20, all channels empty
module line_sensor_position_debounce_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lspd_pkg::sens_t     in_sensors,
  output logic                out_valid,
  input  logic                out_stall,
  output lspd_pkg::err_t      out_turn_error,
  output logic                out_line_seen,
  output logic                out_line_stable,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  lspd_pkg::thr_t      cfg_data
);
  import lspd_pkg::*;

  qstat_t q_stat;
  logic   push;
  logic   pop;
  word_t  push_word;
  word_t  pop_word;

  lspd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sensors (in_sensors),
    .q_stat     (q_stat),
    .push       (push),
    .push_word  (push_word)
  );

  lspd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_stat    (q_stat)
  );

  lspd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop_word        (pop_word),
    .pop             (pop),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_turn_error  (out_turn_error),
    .out_line_seen   (out_line_seen),
    .out_line_stable (out_line_stable)
  );

endmodule

// ===== tb/sv/line_sensor_position_debounce_top_test.sv =====
`timescale 1ns / 1ps

module line_sensor_position_debounce_top_test;
  import lspd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD = 60;

  typedef struct {
    err_t err;
    logic seen;
    logic stable;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sens_t in_sensors = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  err_t out_turn_error;
  logic out_line_seen;
  logic out_line_stable;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  thr_t cfg_data = '0;

  sens_t sensor_words[$];
  tick_result_t results_due[$];
  tick_result_t want_now;

  err_t held_err = '0;
  logic raw_flag = 1'b0;
  logic run_flag = 1'b0;
  logic [7:0] run_len = '0;
  logic steady_flag = 1'b0;
  thr_t run_threshold = THR_RESET;

  int mismatches = 0;
  int send_gap = 0;
  int stall_left = 0;
  int long_cnt = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit long_hold_on = 1'b0;

  line_sensor_position_debounce_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sensors     (in_sensors),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_turn_error (out_turn_error),
    .out_line_seen  (out_line_seen),
    .out_line_stable(out_line_stable),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic kind_t classify_word(input sens_t s, output err_t pos_err);
    int low;
    int e;
    sens_t t;
    pos_err = '0;
    if (s == '0) return KIND_DARK;
    low = 0;
    t = s;
    while (!t[0]) begin
      t = t >> 1;
      low++;
    end
    if (t == sens_t'(1)) e = 55 - 10 * low;
    else if (t == sens_t'(3)) e = 50 - 10 * low;
    else return KIND_OTHER;
    if (e > ERR_MAX) e = ERR_MAX;
    if (e < ERR_MIN) e = ERR_MIN;
    pos_err = err_t'(e);
    return KIND_LINE;
  endfunction

  function automatic sens_t rand_word(input kind_t k);
    sens_t s;
    err_t e;
    case (k)
      KIND_DARK: s = '0;
      KIND_LINE: begin
        if ($urandom_range(0, 1)) s = sens_t'(1) << $urandom_range(0, SENSOR_COUNT - 1);
        else s = sens_t'(3) << $urandom_range(0, SENSOR_COUNT - 2);
      end
      default: begin
        do s = sens_t'($urandom_range(1, 4095));
        while (classify_word(s, e) != KIND_OTHER);
      end
    endcase
    return s;
  endfunction

  task automatic predict_tick(input sens_t s);
    err_t e;
    kind_t k;
    tick_result_t r;
    k = classify_word(s, e);
    if (k == KIND_DARK) begin
      raw_flag = 1'b0;
    end else if (k == KIND_LINE) begin
      held_err = e;
      raw_flag = 1'b1;
    end
    if (raw_flag == run_flag) begin
      if (run_len < run_threshold) run_len++;
      if (run_len >= run_threshold) steady_flag = raw_flag;
    end else begin
      run_len = 8'd1;
      run_flag = raw_flag;
    end
    r.err = held_err;
    r.seen = raw_flag;
    r.stable = steady_flag;
    results_due.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40)
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic queue_runs(input int count, input int max_run);
    int made;
    int len;
    kind_t base;
    sens_t w;
    made = 0;
    while (made < count) begin
      len = $urandom_range(1, max_run);
      base = $urandom_range(0, 1) ? KIND_LINE : KIND_DARK;
      repeat (len) begin
        case ($urandom_range(0, 9))
          0: w = rand_word(KIND_OTHER);
          1: w = sens_t'($urandom_range(0, 4095));
          default: w = rand_word(base);
        endcase
        sensor_words.push_back(w);
        made++;
      end
    end
  endtask

  task automatic write_threshold(input thr_t v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    run_threshold = v;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sensor_words.size() != 0 || in_valid || results_due.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) predict_tick(in_sensors);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (sensor_words.size() > 0) begin
          in_sensors <= sensor_words.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (long_hold_on && long_cnt < LONG_HOLD) begin
      out_stall <= 1'b1;
      long_cnt <= long_cnt + 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with none due", int'(out_turn_error), 0);
      end else begin
        want_now = results_due.pop_front();
        if (out_turn_error !== want_now.err)
          report_mismatch("turn_error", int'(out_turn_error), int'(want_now.err));
        if (out_line_seen !== want_now.seen)
          report_mismatch("line_seen", int'(out_line_seen), int'(want_now.seen));
        if (out_line_stable !== want_now.stable)
          report_mismatch("line_stable", int'(out_line_stable), int'(want_now.stable));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sens_t directed[$];
    directed = '{12'h000, 12'hFFF, 12'h003, 12'h060, 12'hC00, 12'h005, 12'h007,
                 12'h801, 12'hAAA, 12'h555};
    for (int i = 0; i < SENSOR_COUNT; i++) directed.push_back(sens_t'(1) << i);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) sensor_words.push_back(directed[i]);
    queue_runs(80, 26);
    wait_drained();

    write_threshold(thr_t'(1));
    queue_runs(120, 4);
    wait_drained();

    // longest threshold: one line run long enough to saturate, then dark
    write_threshold(thr_t'(255));
    repeat (258) begin
      if ($urandom_range(0, 7) == 0) sensor_words.push_back(rand_word(KIND_OTHER));
      else sensor_words.push_back(rand_word(KIND_LINE));
    end
    repeat (20) sensor_words.push_back(rand_word(KIND_DARK));
    wait_drained();

    write_threshold(thr_t'($urandom_range(2, 30)));
    long_hold_on = 1'b1;
    queue_runs(200, 35);
    wait_drained();
    long_hold_on = 1'b0;

    write_threshold(thr_t'($urandom_range(1, 8)));
    quiet = 1'b1;
    queue_runs(150, 10);
    wait_drained();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lspd_pkg.sv
hw/rtl/lspd_front.sv
hw/rtl/lspd_queue.sv
hw/rtl/lspd_back.sv
hw/rtl/line_sensor_position_debounce_top.sv
tb/sv/line_sensor_position_debounce_top_test.sv
